// ----- hw/rtl/sidm_pkg.sv -----
// Shared types, constants and helpers for the smoothed intensity direction meter.
// No dependencies.
package sidm_pkg;

  localparam int unsigned ONE_Q24 = 32'd16777216;
  localparam int unsigned RECIP_MAX = 32'd65536;
  localparam logic [30:0] LEVEL_MAX = 31'd1073741824;
  localparam logic signed [23:0] ONE_DIR = 24'sd4194304;
  localparam int QDEPTH_DEFAULT = 2;

  localparam logic [0:0] REG_WEIGHT = 1'b0;
  localparam logic [0:0] REG_RECIP = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [23:0] src_x;
    logic signed [23:0] src_y;
    logic signed [23:0] src_z;
    logic chunk_start;
  } in_item_t;

  typedef struct packed {
    logic [30:0] level;
    logic signed [31:0] weighted_x;
    logic signed [31:0] weighted_y;
    logic signed [31:0] weighted_z;
  } out_item_t;

  // Front-to-back queue entry: squared sample plus optional new ramp target.
  typedef struct packed {
    logic [31:0] sq;
    logic chunk_start;
    logic signed [23:0] tx;
    logic signed [23:0] ty;
    logic signed [23:0] tz;
  } work_t;

endpackage

// ----- hw/rtl/sidm_front.sv -----
// Front: accepts items, squares the sample and computes the unit target
// direction at chunk starts with a serial square root and divider. Uses sidm_pkg.
module sidm_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sidm_pkg::in_item_t in_item,
  output logic wk_valid,
  input  logic wk_ready,
  output sidm_pkg::work_t wk_item
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_NORM = 5'b00010,
    S_SQRT = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  sidm_pkg::in_item_t item;
  logic [1:0] idx;
  logic [65:0] n2;
  logic [65:0] rem;
  logic [32:0] root;
  logic [5:0] cnt;
  logic [54:0] dividend;
  logic [54:0] dquo;
  logic [56:0] drem;
  logic signed [23:0] tgt [3];
  logic signed [23:0] comp;
  logic [23:0] mag;
  logic [47:0] sqv;
  logic [67:0] trial;
  logic [56:0] dsh;
  logic [23:0] qclamp;

  // squared magnitude term for the selected component
  always_comb begin
    comp = (idx == 2'd0) ? item.src_x : (idx == 2'd1) ? item.src_y : item.src_z;
    mag = comp[23] ? 24'(-comp) : comp;
    sqv = 48'(mag) * 48'(mag);
    trial = {rem, n2[65:64]} - {33'd0, root, 2'b01};
    dsh = {drem[55:0], dividend[54]};
    qclamp = (dquo > 55'(sidm_pkg::ONE_DIR)) ? 24'(sidm_pkg::ONE_DIR) : dquo[23:0];
  end

  assign in_ready = (state == S_IDLE);
  assign wk_valid = (state == S_OUT);
  assign wk_item.sq = 32'(32'(item.sample) * 32'(item.sample));
  assign wk_item.chunk_start = item.chunk_start;
  assign wk_item.tx = tgt[0];
  assign wk_item.ty = tgt[1];
  assign wk_item.tz = tgt[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_item;
            idx <= 2'd0;
            n2 <= '0;
            state <= in_item.chunk_start ? S_NORM : S_OUT;
          end
        end
        S_NORM: begin
          // last term: scale the sum by 2^16 for the root
          n2 <= (idx == 2'd2) ? ((n2 + {18'd0, sqv}) << 16) : (n2 + {18'd0, sqv});
          if (idx == 2'd2) begin
            state <= S_SQRT;
            cnt <= 6'd0;
            rem <= '0;
            root <= '0;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        S_SQRT: begin
          // isqrt of n2<<16, two bits per cycle
          if (!trial[67]) begin
            rem <= trial[65:0];
            root <= {root[31:0], 1'b1};
          end else begin
            rem <= {rem[63:0], n2[65:64]};
            root <= {root[31:0], 1'b0};
          end
          n2 <= {n2[63:0], 2'b00};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd32) begin
            state <= S_DIV;
            idx <= 2'd0;
            cnt <= 6'd0;
          end
        end
        S_DIV: begin
          if (cnt == 6'd0) begin
            dividend <= ({7'd0, mag, 24'd0} << 6) + 55'(root >> 1);
            drem <= '0;
            dquo <= '0;
            cnt <= 6'd1;
          end else if (cnt <= 6'd55) begin
            if (dsh >= 57'(root)) begin
              drem <= dsh - 57'(root);
              dquo <= {dquo[53:0], 1'b1};
            end else begin
              drem <= dsh;
              dquo <= {dquo[53:0], 1'b0};
            end
            dividend <= {dividend[53:0], 1'b0};
            cnt <= cnt + 6'd1;
          end else begin
            tgt[idx] <= (root == '0) ? '0 : (comp[23] ? 24'(-qclamp) : qclamp);
            cnt <= 6'd0;
            if (idx == 2'd2) state <= S_OUT;
            else idx <= idx + 2'd1;
          end
        end
        S_OUT: begin
          if (wk_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sidm_queue.sv -----
// Short FIFO between front and back. Uses sidm_pkg.
module sidm_queue #(
  parameter int DEPTH = sidm_pkg::QDEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  sidm_pkg::work_t din,
  input  logic pop,
  output logic empty,
  output sidm_pkg::work_t dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  sidm_pkg::work_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] count;

  assign full = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp] <= din;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push && !full) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      if (pop && !empty) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(DEPTH))
    else $error("queue overflow");
  a_emp: assert property (@(posedge clk) disable iff (rst)
    (empty && !push) |=> empty) else $error("queue grew without push");
  a_full: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |=> full) else $error("queue shrank without pop");
`endif

endmodule

// ----- hw/rtl/sidm_back.sv -----
// Back: ramp step, direction update, one-pole level and weighted outputs,
// stepped by a sequencer into a result register. Uses sidm_pkg.
module sidm_back (
  input  logic clk,
  input  logic rst,
  input  logic [24:0] smoothing_weight,
  input  logic [16:0] chunk_reciprocal,
  input  logic wk_valid,
  output logic wk_ready,
  input  sidm_pkg::work_t wk_item,
  output logic res_valid,
  input  logic res_ready,
  output sidm_pkg::out_item_t res_item
);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_STEP = 6'b000010,
    B_DIR  = 6'b000100,
    B_LVLA = 6'b001000,
    B_LVLB = 6'b010000,
    B_WGT  = 6'b100000
  } bstate_t;

  bstate_t state;
  sidm_pkg::work_t w;
  logic [1:0] idx;
  logic signed [23:0] dir [3];
  logic signed [23:0] step [3];
  logic [30:0] level;
  logic signed [63:0] acc;
  logic signed [31:0] wres [2];
  sidm_pkg::out_item_t res_q;
  logic out_full;

  logic [24:0] wc;
  logic [16:0] rc;
  logic signed [24:0] diff;
  logic signed [42:0] prod_s;
  logic signed [42:0] sround;
  logic signed [24:0] dsum [3];
  logic signed [55:0] wprod;
  logic signed [55:0] wround;
  logic signed [31:0] wsat;

  function automatic logic signed [55:0] rhaz(input logic signed [55:0] v, input int s);
    logic [55:0] m;
    m = v[55] ? 56'(-v) : 56'(v);
    m = (m + (56'd1 << (s - 1))) >> s;
    return v[55] ? -$signed(m) : $signed(m);
  endfunction

  always_comb begin
    wc = (smoothing_weight > 25'(sidm_pkg::ONE_Q24)) ? 25'(sidm_pkg::ONE_Q24) : smoothing_weight;
    rc = (chunk_reciprocal > 17'(sidm_pkg::RECIP_MAX)) ? 17'(sidm_pkg::RECIP_MAX)
         : chunk_reciprocal;
    diff = ((idx == 2'd0) ? 25'(w.tx) : (idx == 2'd1) ? 25'(w.ty) : 25'(w.tz)) - 25'(dir[idx]);
    prod_s = 43'(diff) * $signed({1'b0, rc});
    sround = 43'(rhaz(56'(prod_s), 16));
    for (int i = 0; i < 3; i++) dsum[i] = 25'(dir[i]) + 25'(step[i]);
    wprod = 56'(dir[idx]) * $signed({25'd0, level});
    wround = rhaz(wprod, 22);
    wsat = (wround > 56'sd1073741824) ? 32'sd1073741824
         : (wround < -56'sd1073741824) ? -32'sd1073741824 : 32'(wround);
  end

  assign wk_ready = (state == B_IDLE);
  assign res_valid = out_full;
  assign res_item = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_full <= 1'b0;
      level <= '0;
      for (int i = 0; i < 3; i++) begin
        dir[i] <= '0;
        step[i] <= '0;
      end
    end else begin
      if (res_valid && res_ready) out_full <= 1'b0;
      case (state)
        B_IDLE: begin
          if (wk_valid) begin
            w <= wk_item;
            idx <= 2'd0;
            state <= wk_item.chunk_start ? B_STEP : B_DIR;
          end
        end
        B_STEP: begin
          step[idx] <= (sround > 43'sd8388607) ? 24'sh7FFFFF
                     : (sround < -43'sd8388608) ? 24'sh800000 : 24'(sround);
          if (idx == 2'd2) begin
            idx <= 2'd0;
            state <= B_DIR;
          end else idx <= idx + 2'd1;
        end
        B_DIR: begin
          // direction advance with 24-bit saturation
          for (int i = 0; i < 3; i++) begin
            dir[i] <= (dsum[i] > 25'sd8388607) ? 24'sh7FFFFF
                    : (dsum[i] < -25'sd8388608) ? 24'sh800000 : 24'(dsum[i]);
          end
          state <= B_LVLA;
        end
        B_LVLA: begin
          acc <= 64'(w.sq) * 64'(wc);
          state <= B_LVLB;
        end
        B_LVLB: begin
          if ((64'(acc) + 64'(level) * 64'(26'(sidm_pkg::ONE_Q24) - 26'(wc)) + 64'd8388608)
              >> 24 > 64'(sidm_pkg::LEVEL_MAX))
            level <= sidm_pkg::LEVEL_MAX;
          else
            level <= 31'((64'(acc) + 64'(level) * 64'(26'(sidm_pkg::ONE_Q24) - 26'(wc))
                     + 64'd8388608) >> 24);
          idx <= 2'd0;
          state <= B_WGT;
        end
        B_WGT: begin
          if (idx == 2'd2) begin
            // last component goes straight into the result register
            if (!out_full) begin
              res_q <= {level, wres[0], wres[1], wsat};
              out_full <= 1'b1;
              state <= B_IDLE;
            end
          end else begin
            wres[idx[0]] <= wsat;
            idx <= idx + 2'd1;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_lvl: assert property (@(posedge clk) disable iff (rst) level <= sidm_pkg::LEVEL_MAX)
    else $error("level exceeds one");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid) else $error("result dropped");
  a_one: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
`endif

endmodule

// ----- hw/rtl/smoothed_intensity_direction_meter.sv -----
// Top level of the smoothed intensity direction meter.
// Uses sidm_pkg, sidm_front, sidm_queue, sidm_back.
// The front and the back each work on one item at a time; the queue between them lets
// the front take a new item while the back finishes the last. A chunk start adds the square
// root and one serial divide per component in the front, and the ramp step in the back.
// Reset (rst, synchronous): registers to defaults, level/direction/steps to zero.
module smoothed_intensity_direction_meter #(
  parameter int QDEPTH = sidm_pkg::QDEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  sidm_pkg::in_item_t din,
  output logic empty,
  input  logic pop,
  output sidm_pkg::out_item_t dout,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [31:0] cfg_data
);

  logic [24:0] smoothing_weight;
  logic [16:0] chunk_reciprocal;
  logic in_ready, fq_valid, fq_full, bq_empty, bk_ready;
  sidm_pkg::work_t fq_item, bq_item;
  logic res_valid;

  // configuration writes always taken
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_weight <= 25'd2796;
      chunk_reciprocal <= 17'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        sidm_pkg::REG_WEIGHT: smoothing_weight <= cfg_data[24:0];
        sidm_pkg::REG_RECIP: chunk_reciprocal <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign full = !in_ready;

  sidm_front u_front (
    .clk, .rst,
    .in_valid(push), .in_ready, .in_item(din),
    .wk_valid(fq_valid), .wk_ready(!fq_full), .wk_item(fq_item)
  );

  sidm_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst,
    .push(fq_valid), .full(fq_full), .din(fq_item),
    .pop(bk_ready), .empty(bq_empty), .dout(bq_item)
  );

  sidm_back u_back (
    .clk, .rst, .smoothing_weight, .chunk_reciprocal,
    .wk_valid(!bq_empty), .wk_ready(bk_ready), .wk_item(bq_item),
    .res_valid, .res_ready(pop), .res_item(dout)
  );

  assign empty = !res_valid;

`ifndef SYNTHESIS
  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port stalled");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty) else $error("result lost");
  a_push: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full) else $error("front took two items");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for the smoothed intensity direction meter: table-driven directed items,
// extreme settings, then random bursts of chunks, all checked against an in-bench predictor.
// Depends on sidm_pkg and smoothed_intensity_direction_meter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  sidm_pkg::in_item_t din = '0;
  logic empty;
  logic pop = 1'b0;
  sidm_pkg::out_item_t dout;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = sidm_pkg::REG_WEIGHT;
  logic [31:0] cfg_data = '0;

  smoothed_intensity_direction_meter uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .din(din),
    .empty(empty), .pop(pop), .dout(dout),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state, mirrors the block's registers and datapath state.
  longint unsigned weight_reg, recip_reg;
  longint unsigned lvl_acc;
  longint dir_acc[3];
  longint step_acc[3];

  sidm_pkg::out_item_t pending_q[$];
  int errors = 0;
  int n_seen = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Shift right with round half away from zero.
  function automatic longint rnd_shr(longint v, int s);
    longint unsigned m;
    m = v < 0 ? longint'(-v) : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // One component of the unit target direction, Q2.22.
  function automatic longint unit_dir(longint p, longint unsigned r);
    longint unsigned m, q;
    if (r == 0) return 0;
    m = p < 0 ? longint'(-p) : p;
    q = ((m << 30) + (r >> 1)) / r;
    if (q > 64'd4194304) q = 64'd4194304;
    return p < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic sidm_pkg::out_item_t meter_predict(sidm_pkg::in_item_t it);
    sidm_pkg::out_item_t o;
    longint s, p[3];
    longint unsigned sq, w, rc, n2, r;
    s = it.sample;
    sq = s * s;
    w = weight_reg > 64'd16777216 ? 64'd16777216 : weight_reg;
    if (it.chunk_start) begin
      p[0] = it.src_x;
      p[1] = it.src_y;
      p[2] = it.src_z;
      n2 = p[0] * p[0] + p[1] * p[1] + p[2] * p[2];
      r = int_sqrt(n2 << 16);
      rc = recip_reg > 64'd65536 ? 64'd65536 : recip_reg;
      for (int i = 0; i < 3; i++)
        step_acc[i] = clip(rnd_shr((unit_dir(p[i], r) - dir_acc[i]) * longint'(rc), 16),
                           -8388608, 8388607);
    end
    for (int i = 0; i < 3; i++)
      dir_acc[i] = clip(dir_acc[i] + step_acc[i], -8388608, 8388607);
    lvl_acc = (w * sq + (64'd16777216 - w) * lvl_acc + 64'd8388608) >> 24;
    if (lvl_acc > 64'd1073741824) lvl_acc = 64'd1073741824;
    o.level = lvl_acc[30:0];
    o.weighted_x = 32'(clip(rnd_shr(dir_acc[0] * longint'(lvl_acc), 22), -1073741824, 1073741824));
    o.weighted_y = 32'(clip(rnd_shr(dir_acc[1] * longint'(lvl_acc), 22), -1073741824, 1073741824));
    o.weighted_z = 32'(clip(rnd_shr(dir_acc[2] * longint'(lvl_acc), 22), -1073741824, 1073741824));
    return o;
  endfunction

  // Result side: compare every popped result with the oldest expectation.
  logic stall_mode = 1'b0;
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      n_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, got %h", $time, dout);
        errors++;
      end else begin
        sidm_pkg::out_item_t e;
        e = pending_q.pop_front();
        if (dout.level !== e.level) begin
          $display("%0t: level expected %0d actual %0d", $time, e.level, dout.level);
          errors++;
        end
        if (dout.weighted_x !== e.weighted_x) begin
          $display("%0t: weighted_x expected %0d actual %0d", $time, e.weighted_x,
                   dout.weighted_x);
          errors++;
        end
        if (dout.weighted_y !== e.weighted_y) begin
          $display("%0t: weighted_y expected %0d actual %0d", $time, e.weighted_y,
                   dout.weighted_y);
          errors++;
        end
        if (dout.weighted_z !== e.weighted_z) begin
          $display("%0t: weighted_z expected %0d actual %0d", $time, e.weighted_z,
                   dout.weighted_z);
          errors++;
        end
      end
    end
    // Receiver stall pattern: long stretches either free-running or choppy.
    if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
    pop <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 15) != 0);
  end

  // Sender: hold push until the item is taken; push drops only in gaps.
  int burst_left = 0;
  task automatic send_item(sidm_pkg::in_item_t it);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    push <= 1'b1;
    din <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_q.push_back(meter_predict(it));
  endtask

  // Wait for the block to drain, then for as long as a chunk start takes to pass through.
  task automatic drain;
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == sidm_pkg::REG_WEIGHT) weight_reg = val & 32'h1FFFFFF;
    else recip_reg = val & 32'h1FFFF;
    @(posedge clk);
  endtask

  function automatic sidm_pkg::in_item_t make_item(int s, int x, int y, int z, bit c);
    sidm_pkg::in_item_t it;
    it.sample = 16'(s);
    it.src_x = 24'(x);
    it.src_y = 24'(y);
    it.src_z = 24'(z);
    it.chunk_start = c;
    return it;
  endfunction

  function automatic int rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 200) - 100;
      1: return $urandom_range(0, 1) ? 8388607 : -8388608;
      default: return int'({{8{1'b0}}, 24'($urandom)}) - 8388608;
    endcase
  endfunction

  typedef struct {
    sidm_pkg::in_item_t it;
    bit known;
    sidm_pkg::out_item_t exp_val;
  } stim_row_t;

  stim_row_t dir_tab[$];

  initial begin
    sidm_pkg::in_item_t it;
    sidm_pkg::out_item_t got;
    int chunk_len;
    weight_reg = 2796;
    recip_reg = 256;
    lvl_acc = 0;
    for (int i = 0; i < 3; i++) begin
      dir_acc[i] = 0;
      step_acc[i] = 0;
    end

    // Directed rows. After reset, a zero sample with no chunk start gives all zeros.
    dir_tab.push_back('{make_item(0, 5, 5, 5, 0), 1'b1, '0});
    dir_tab.push_back('{make_item(0, 0, 0, 0, 1), 1'b1, '0});          // zero position
    dir_tab.push_back('{make_item(-32768, 8388607, 0, 0, 1), 1'b0, '0});
    dir_tab.push_back('{make_item(32767, -8388608, 8388607, -8388608, 1), 1'b0, '0});
    dir_tab.push_back('{make_item(32767, 1, 1, 1, 0), 1'b0, '0});       // position ignored
    dir_tab.push_back('{make_item(-1, 0, 0, -8388608, 1), 1'b0, '0});
    dir_tab.push_back('{make_item(1, 0, -1, 0, 1), 1'b0, '0});
    for (int k = 0; k < 5; k++)
      dir_tab.push_back('{make_item(-32768, 0, 0, 0, 0), 1'b0, '0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      send_item(dir_tab[k].it);
      if (dir_tab[k].known) begin
        got = pending_q[pending_q.size() - 1];
        if (got !== dir_tab[k].exp_val) begin
          $display("%0t: row %0d expected %h actual %h", $time, k, dir_tab[k].exp_val, got);
          errors++;
        end
      end
    end
    drain();

    // Extremes: weight one and above one, fastest ramp, then saturating steps, then weight and ramp rate zero.
    write_reg(sidm_pkg::REG_WEIGHT, 32'd16777216);
    write_reg(sidm_pkg::REG_RECIP, 32'd65536);
    send_item(make_item(-32768, 8388607, 8388607, 8388607, 1));
    send_item(make_item(-32768, -8388608, 0, 0, 1));
    send_item(make_item(12345, 0, 0, 0, 0));
    drain();
    write_reg(sidm_pkg::REG_WEIGHT, 32'h1FFFFFF);
    write_reg(sidm_pkg::REG_RECIP, 32'h1FFFF);
    send_item(make_item(-32768, 0, -8388608, 0, 1));
    for (int k = 0; k < 6; k++) send_item(make_item(32767, 0, 0, 0, 0));
    drain();
    write_reg(sidm_pkg::REG_WEIGHT, 32'd0);
    write_reg(sidm_pkg::REG_RECIP, 32'd0);
    send_item(make_item(-32768, 3, -4, 5, 1));
    send_item(make_item(1000, 0, 0, 0, 0));
    drain();

    // Random phases with varied settings, reset defaults among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(sidm_pkg::REG_WEIGHT, 2796);
          write_reg(sidm_pkg::REG_RECIP, 256);
        end
        1: begin
          write_reg(sidm_pkg::REG_WEIGHT, 1);
          write_reg(sidm_pkg::REG_RECIP, 1);
        end
        2: begin
          write_reg(sidm_pkg::REG_WEIGHT, 16777216);
          write_reg(sidm_pkg::REG_RECIP, 65536);
        end
        3: begin
          write_reg(sidm_pkg::REG_WEIGHT, 32'h1FFFFFF);
          write_reg(sidm_pkg::REG_RECIP, 32'h1FFFF);
        end
        default: begin
          write_reg(sidm_pkg::REG_WEIGHT, $urandom_range(0, 33554431));
          write_reg(sidm_pkg::REG_RECIP, $urandom_range(0, 131071));
        end
      endcase
      for (int n = 0; n < 300;) begin
        chunk_len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : $urandom_range(5, 40);
        for (int k = 0; k < chunk_len && n < 300; k++, n++) begin
          it = make_item($urandom, rand_pos(), rand_pos(), rand_pos(), k == 0);
          if ($urandom_range(0, 19) == 0) it.chunk_start = $urandom_range(0, 1);
          if ($urandom_range(0, 15) == 0) it.sample = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
          send_item(it);
        end
        // Hold-off until everything has drained, now and then.
        if ($urandom_range(0, 9) == 0) begin
          push <= 1'b0;
          while (pending_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("testbench: errors");
    $finish;
  end

endmodule
